[design/sphere_pair_collision_resolve_defines.svh]
// Assertion macros shared by the sphere pair collision resolver.
// No dependencies; include with the bare file name.
`ifndef SPHERE_PAIR_COLLISION_RESOLVE_DEFINES_SVH
`define SPHERE_PAIR_COLLISION_RESOLVE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SPCR_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define SPCR_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define SPCR_ASSERT_IMP(name, clk, rst, ante, cons)
`define SPCR_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

[design/spcr_pkg.sv]
// Types, constants and helpers of the sphere pair collision resolver.
// No dependencies; every module imports it.
package spcr_pkg;

   localparam int NORM_BITS   = 30;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic [33:0] J_MAX    = 34'h3_FFFF_FFFF;
   localparam logic [30:0] NORM_ONE = 31'h4000_0000;

   localparam logic [1:0] CSR_RADIUS      = 2'd0;
   localparam logic [1:0] CSR_RESTITUTION = 2'd1;

   typedef struct packed {
      logic signed [31:0] first_pos_x;
      logic signed [31:0] first_pos_y;
      logic signed [31:0] first_pos_z;
      logic signed [31:0] second_pos_x;
      logic signed [31:0] second_pos_y;
      logic signed [31:0] second_pos_z;
      logic signed [31:0] first_vel_x;
      logic signed [31:0] first_vel_y;
      logic signed [31:0] first_vel_z;
      logic signed [31:0] second_vel_x;
      logic signed [31:0] second_vel_y;
      logic signed [31:0] second_vel_z;
   } req_type;

   typedef struct packed {
      logic               which_sphere;
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_pos_z;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] new_vel_z;
      logic               collided;
      logic               last_of_pair;
   } rsp_type;

   typedef struct packed {
      req_type          item;
      logic             cand;
      logic [61:0]      dsq;
      logic [2:0][30:0] dm;
      logic [2:0]       dn;
      logic [2:0][32:0] rm;
      logic [2:0]       rn;
   } qent_type;

   typedef struct packed {
      logic     push;
      qent_type entry;
   } qpush_type;

   typedef struct packed {
      logic              empty;
      logic [QCNT_W-1:0] fill;
   } qstat_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_SQRT,
      BK_DIV_LOAD,
      BK_DIV,
      BK_DOT_MUL,
      BK_DOT_ACC,
      BK_SCALE_M,
      BK_J_MUL,
      BK_J_RND,
      BK_AP_MUL,
      BK_AP_ADD,
      BK_EMIT_FIRST,
      BK_EMIT_SECOND
   } back_state_type;

   function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
      if (v > 37'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -37'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

endpackage

[design/spcr_front.sv]
// Front end: accepts pairs, forms differences and squared distance, classifies.
// Depends on spcr_pkg; feeds spcr_queue.
module spcr_front import spcr_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   input  logic [30:0] rs,
   input  qstat_type   qstat,
   output qpush_type   qpush
);

   localparam logic [63:0] EPS_VAL =
      64'(((64'd1 << (2 * FRAC_BITS)) + 64'd999999999999) / 64'd1000000000000);

   logic signed [31:0] p1 [3];
   logic signed [31:0] p2 [3];
   logic signed [31:0] v1 [3];
   logic signed [31:0] v2 [3];
   logic signed [32:0] pd [3];
   logic signed [32:0] vd [3];
   logic [32:0]        pm [3];
   logic [32:0]        vm [3];
   logic               near;
   logic               accept;

   logic             s1_vld_ff;
   req_type          s1_item_ff;
   logic [2:0][30:0] s1_dm_ff;
   logic [2:0]       s1_dn_ff;
   logic [2:0][32:0] s1_rm_ff;
   logic [2:0]       s1_rn_ff;
   logic             s1_near_ff;

   logic             s2_vld_ff;
   req_type          s2_item_ff;
   logic [2:0][30:0] s2_dm_ff;
   logic [2:0]       s2_dn_ff;
   logic [2:0][32:0] s2_rm_ff;
   logic [2:0]       s2_rn_ff;
   logic             s2_near_ff;
   logic [61:0]      s2_sq_ff [3];
   logic [61:0]      s2_rs2_ff;

   logic [63:0] dsq;

   always_comb begin
      p1[0] = req_data.first_pos_x;
      p1[1] = req_data.first_pos_y;
      p1[2] = req_data.first_pos_z;
      p2[0] = req_data.second_pos_x;
      p2[1] = req_data.second_pos_y;
      p2[2] = req_data.second_pos_z;
      v1[0] = req_data.first_vel_x;
      v1[1] = req_data.first_vel_y;
      v1[2] = req_data.first_vel_z;
      v2[0] = req_data.second_vel_x;
      v2[1] = req_data.second_vel_y;
      v2[2] = req_data.second_vel_z;
      near = 1'b1;
      for (int i = 0; i < 3; i++) begin
         pd[i] = {p1[i][31], p1[i]} - {p2[i][31], p2[i]};
         vd[i] = {v1[i][31], v1[i]} - {v2[i][31], v2[i]};
         pm[i] = pd[i][32] ? 33'(-pd[i]) : 33'(pd[i]);
         vm[i] = vd[i][32] ? 33'(-vd[i]) : 33'(vd[i]);
         if (pm[i] >= {2'b00, rs}) begin
            near = 1'b0;
         end
      end
   end

   assign busy   = (3'(qstat.fill) + 3'(s1_vld_ff) + 3'(s2_vld_ff)) >= 3'(QUEUE_DEPTH);
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_data;
         s1_near_ff <= near;
         for (int i = 0; i < 3; i++) begin
            s1_dm_ff[i] <= pm[i][30:0];
            s1_dn_ff[i] <= pd[i][32];
            s1_rm_ff[i] <= vm[i];
            s1_rn_ff[i] <= vd[i][32];
         end
      end
      if (s1_vld_ff) begin
         s2_item_ff <= s1_item_ff;
         s2_near_ff <= s1_near_ff;
         s2_dm_ff   <= s1_dm_ff;
         s2_dn_ff   <= s1_dn_ff;
         s2_rm_ff   <= s1_rm_ff;
         s2_rn_ff   <= s1_rn_ff;
         s2_rs2_ff  <= 62'(rs) * 62'(rs);
         for (int i = 0; i < 3; i++) begin
            s2_sq_ff[i] <= 62'(s1_dm_ff[i]) * 62'(s1_dm_ff[i]);
         end
      end
   end

   assign dsq = 64'(s2_sq_ff[0]) + 64'(s2_sq_ff[1]) + 64'(s2_sq_ff[2]);

   always_comb begin
      qpush.push       = s2_vld_ff;
      qpush.entry.item = s2_item_ff;
      qpush.entry.cand = s2_near_ff && (dsq < {2'b00, s2_rs2_ff}) && (dsq >= EPS_VAL)
                         && (dsq != 64'd0);
      qpush.entry.dsq  = dsq[61:0];
      qpush.entry.dm   = s2_dm_ff;
      qpush.entry.dn   = s2_dn_ff;
      qpush.entry.rm   = s2_rm_ff;
      qpush.entry.rn   = s2_rn_ff;
   end

endmodule

[design/spcr_queue.sv]
// Short queue of classified items between the front end and the back end.
// Depends on spcr_pkg.
module spcr_queue import spcr_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  qpush_type qpush,
   input  logic      pop,
   output qent_type  head,
   output qstat_type qstat
);

   qent_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff;
   logic [QPTR_W-1:0]  rd_ptr_ff;
   logic [QCNT_W-1:0]  fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (qpush.push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         fill_ff <= fill_ff + QCNT_W'(qpush.push) - QCNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (qpush.push) begin
         slot_ff[wr_ptr_ff] <= qpush.entry;
      end
   end

   assign head        = slot_ff[rd_ptr_ff];
   assign qstat.empty = (fill_ff == '0);
   assign qstat.fill  = fill_ff;

endmodule

[design/spcr_back.sv]
// Back end: square root, normal division, dot product, impulse and push-out.
// Depends on spcr_pkg and the assertion macro header; drains spcr_queue.
`include "sphere_pair_collision_resolve_defines.svh"
module spcr_back import spcr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  qent_type    head,
   input  qstat_type   qstat,
   output logic        pop,
   input  logic [30:0] rs,
   input  logic [16:0] restitution,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   back_state_type state_ff;
   back_state_type state_in;

   logic signed [31:0] p1_ff [3];
   logic signed [31:0] p2_ff [3];
   logic signed [31:0] v1_ff [3];
   logic signed [31:0] v2_ff [3];
   logic               cand_ff;
   logic [30:0]        dm_ff [3];
   logic [2:0]         dn_ff;
   logic [32:0]        rm_ff [3];
   logic [2:0]         rn_ff;

   logic [61:0] sqv_ff;
   logic [32:0] sq_rem_ff;
   logic [30:0] root_ff;
   logic [4:0]  step_ff;

   logic [30:0] dv_num_ff [3];
   logic [31:0] dv_rem_ff [3];
   logic [30:0] nm_ff [3];

   logic [1:0]  ax_ff;
   logic [63:0] prod_ff;
   logic        pneg_ff;
   logic [63:0] pos_ff;
   logic [63:0] neg_ff;
   logic        hit_ff;
   logic [34:0] m_ff;
   logic [30:0] ov_ff;
   logic [52:0] jp_ff;
   logic [33:0] j_ff;
   logic [64:0] ip_ff;
   logic [61:0] cp_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   logic emit_first;
   logic emit_second;

   logic [32:0] sq_rt;
   logic [32:0] sq_trial;
   logic        sq_ge;
   logic [31:0] dv_r2 [3];
   logic [2:0]  dv_ge;
   logic [30:0] dv_q [3];
   logic [61:0] dl_n [3];
   logic [63:0] diff;
   logic [35:0] j_rnd;
   logic [34:0] imp_mag;
   logic [30:0] cor_mag;
   logic signed [36:0] imp_s;
   logic signed [36:0] cor_s;

   always_comb begin
      sq_rt    = {sq_rem_ff[30:0], sqv_ff[61:60]};
      sq_trial = {root_ff, 2'b01};
      sq_ge    = sq_rt >= sq_trial;
      for (int i = 0; i < 3; i++) begin
         dl_n[i]  = {1'b0, dm_ff[i], 30'd0} + {32'd0, root_ff[30:1]};
         dv_r2[i] = {dv_rem_ff[i][30:0], dv_num_ff[i][30]};
         dv_ge[i] = dv_r2[i] >= {1'b0, root_ff};
         dv_q[i]  = {nm_ff[i][29:0], dv_ge[i]};
      end
      diff    = neg_ff - pos_ff;
      j_rnd   = 36'(jp_ff >> 17) + 36'(jp_ff[16]);
      imp_mag = 35'(ip_ff >> NORM_BITS) + 35'(ip_ff[NORM_BITS-1]);
      cor_mag = 31'(cp_ff >> (NORM_BITS + 1)) + 31'(cp_ff[NORM_BITS]);
      imp_s   = dn_ff[ax_ff] ? -$signed({2'b00, imp_mag}) : $signed({2'b00, imp_mag});
      cor_s   = dn_ff[ax_ff] ? -$signed({6'd0, cor_mag}) : $signed({6'd0, cor_mag});
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!qstat.empty) begin
               state_in = head.cand ? BK_SQRT : BK_EMIT_FIRST;
            end
         end
         BK_SQRT:     state_in = (step_ff == 5'd30) ? BK_DIV_LOAD : BK_SQRT;
         BK_DIV_LOAD: state_in = BK_DIV;
         BK_DIV:      state_in = (step_ff == 5'd30) ? BK_DOT_MUL : BK_DIV;
         BK_DOT_MUL:  state_in = BK_DOT_ACC;
         BK_DOT_ACC:  state_in = (ax_ff == 2'd2) ? BK_SCALE_M : BK_DOT_MUL;
         BK_SCALE_M:  state_in = (pos_ff <= neg_ff) ? BK_J_MUL : BK_EMIT_FIRST;
         BK_J_MUL:    state_in = BK_J_RND;
         BK_J_RND:    state_in = BK_AP_MUL;
         BK_AP_MUL:   state_in = BK_AP_ADD;
         BK_AP_ADD:   state_in = (ax_ff == 2'd2) ? BK_EMIT_FIRST : BK_AP_MUL;
         BK_EMIT_FIRST: state_in = BK_EMIT_SECOND;
         BK_EMIT_SECOND: begin
            if (qstat.empty) begin
               state_in = BK_IDLE;
            end else begin
               state_in = head.cand ? BK_SQRT : BK_EMIT_FIRST;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop         = 1'b0;
      emit_first  = 1'b0;
      emit_second = 1'b0;
      unique case (state_ff)
         BK_IDLE:       pop = !qstat.empty;
         BK_EMIT_FIRST: emit_first = 1'b1;
         BK_EMIT_SECOND: begin
            emit_second = 1'b1;
            pop         = !qstat.empty;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= emit_first || emit_second;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         p1_ff[0] <= head.item.first_pos_x;
         p1_ff[1] <= head.item.first_pos_y;
         p1_ff[2] <= head.item.first_pos_z;
         p2_ff[0] <= head.item.second_pos_x;
         p2_ff[1] <= head.item.second_pos_y;
         p2_ff[2] <= head.item.second_pos_z;
         v1_ff[0] <= head.item.first_vel_x;
         v1_ff[1] <= head.item.first_vel_y;
         v1_ff[2] <= head.item.first_vel_z;
         v2_ff[0] <= head.item.second_vel_x;
         v2_ff[1] <= head.item.second_vel_y;
         v2_ff[2] <= head.item.second_vel_z;
         cand_ff   <= head.cand;
         dn_ff     <= head.dn;
         rn_ff     <= head.rn;
         for (int i = 0; i < 3; i++) begin
            dm_ff[i] <= head.dm[i];
            rm_ff[i] <= head.rm[i];
         end
         sqv_ff    <= head.dsq;
         sq_rem_ff <= '0;
         root_ff   <= '0;
         step_ff   <= '0;
         ax_ff     <= '0;
         pos_ff    <= '0;
         neg_ff    <= '0;
         hit_ff    <= 1'b0;
      end
      unique case (state_ff)
         BK_SQRT: begin
            sqv_ff    <= {sqv_ff[59:0], 2'b00};
            sq_rem_ff <= sq_ge ? sq_rt - sq_trial : sq_rt;
            root_ff   <= {root_ff[29:0], sq_ge};
            step_ff   <= (step_ff == 5'd30) ? 5'd0 : step_ff + 5'd1;
         end
         BK_DIV_LOAD: begin
            for (int i = 0; i < 3; i++) begin
               dv_rem_ff[i] <= {1'b0, dl_n[i][61:31]};
               dv_num_ff[i] <= dl_n[i][30:0];
               nm_ff[i]     <= '0;
            end
            step_ff <= '0;
         end
         BK_DIV: begin
            for (int i = 0; i < 3; i++) begin
               dv_rem_ff[i] <= dv_ge[i] ? dv_r2[i] - {1'b0, root_ff} : dv_r2[i];
               dv_num_ff[i] <= {dv_num_ff[i][29:0], 1'b0};
               if (step_ff == 5'd30 && dv_q[i] > NORM_ONE) begin
                  nm_ff[i] <= NORM_ONE;
               end else begin
                  nm_ff[i] <= dv_q[i];
               end
            end
            step_ff <= (step_ff == 5'd30) ? 5'd0 : step_ff + 5'd1;
         end
         BK_DOT_MUL: begin
            prod_ff <= 64'(rm_ff[ax_ff]) * 64'(nm_ff[ax_ff]);
            pneg_ff <= rn_ff[ax_ff] ^ dn_ff[ax_ff];
         end
         BK_DOT_ACC: begin
            if (pneg_ff) begin
               neg_ff <= neg_ff + prod_ff;
            end else begin
               pos_ff <= pos_ff + prod_ff;
            end
            ax_ff <= (ax_ff == 2'd2) ? 2'd0 : ax_ff + 2'd1;
         end
         BK_SCALE_M: begin
            hit_ff <= pos_ff <= neg_ff;
            m_ff   <= 35'(diff >> NORM_BITS) + 35'(diff[NORM_BITS-1]);
            ov_ff  <= rs - root_ff;
         end
         BK_J_MUL: begin
            jp_ff <= 53'(m_ff) * 53'(18'(restitution) + 18'd65536);
         end
         BK_J_RND: begin
            j_ff <= (j_rnd > 36'(J_MAX)) ? J_MAX : j_rnd[33:0];
         end
         BK_AP_MUL: begin
            ip_ff <= 65'(nm_ff[ax_ff]) * 65'(j_ff);
            cp_ff <= 62'(nm_ff[ax_ff]) * 62'(ov_ff);
         end
         BK_AP_ADD: begin
            v1_ff[ax_ff] <= sat32({{5{v1_ff[ax_ff][31]}}, v1_ff[ax_ff]} + imp_s);
            v2_ff[ax_ff] <= sat32({{5{v2_ff[ax_ff][31]}}, v2_ff[ax_ff]} - imp_s);
            p1_ff[ax_ff] <= sat32({{5{p1_ff[ax_ff][31]}}, p1_ff[ax_ff]} + cor_s);
            p2_ff[ax_ff] <= sat32({{5{p2_ff[ax_ff][31]}}, p2_ff[ax_ff]} - cor_s);
            ax_ff        <= (ax_ff == 2'd2) ? 2'd0 : ax_ff + 2'd1;
         end
         default: ;
      endcase
      if (emit_first) begin
         rsp_ff.which_sphere <= 1'b0;
         rsp_ff.new_pos_x    <= p1_ff[0];
         rsp_ff.new_pos_y    <= p1_ff[1];
         rsp_ff.new_pos_z    <= p1_ff[2];
         rsp_ff.new_vel_x    <= v1_ff[0];
         rsp_ff.new_vel_y    <= v1_ff[1];
         rsp_ff.new_vel_z    <= v1_ff[2];
         rsp_ff.collided     <= hit_ff;
         rsp_ff.last_of_pair <= 1'b0;
      end else if (emit_second) begin
         rsp_ff.which_sphere <= 1'b1;
         rsp_ff.new_pos_x    <= p2_ff[0];
         rsp_ff.new_pos_y    <= p2_ff[1];
         rsp_ff.new_pos_z    <= p2_ff[2];
         rsp_ff.new_vel_x    <= v2_ff[0];
         rsp_ff.new_vel_y    <= v2_ff[1];
         rsp_ff.new_vel_z    <= v2_ff[2];
         rsp_ff.collided     <= hit_ff;
         rsp_ff.last_of_pair <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SPCR_ASSERT_NEXT(a_second_follows_first, clock, reset, rsp_valid_ff && !rsp_ff.last_of_pair, rsp_valid_ff && rsp_ff.last_of_pair)
   `SPCR_ASSERT_IMP(a_pair_same_flag, clock, reset, rsp_valid_ff && rsp_ff.last_of_pair, rsp_ff.collided == $past(rsp_ff.collided))
   `SPCR_ASSERT_IMP(a_root_only_for_candidates, clock, reset, state_ff == BK_SQRT, cand_ff)

endmodule

[design/sphere_pair_collision_resolve.sv]
// Out-of-range pairs skip the square root and divider, and separating pairs skip the
// impulse steps; the second result of a pair follows in the next cycle.
// The back end works on one pair at a time, through the bit-serial square root and
// 31-step normal divider; a 4-entry queue decouples the front, which takes pairs until busy.
// Reset is synchronous and active high: radius 1.0, restitution 0.5, queue empty.
// Depends on spcr_pkg, spcr_front, spcr_queue and spcr_back.
module sphere_pair_collision_resolve import spcr_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [29:0] radius_ff;
   logic [16:0] restitution_ff;
   logic [30:0] rs;
   qpush_type   qpush;
   qstat_type   qstat;
   qent_type    head;
   logic        pop;

   assign csr_ready = 1'b1;
   assign rs        = {radius_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff      <= 30'(64'd1 << FRAC_BITS);
         restitution_ff <= 17'd32768;
      end else if (csr_valid && csr_ready) begin
         priority if (csr_index == CSR_RADIUS) begin
            radius_ff <= csr_wdata[29:0];
         end else if (csr_index == CSR_RESTITUTION) begin
            restitution_ff <= csr_wdata[16:0];
         end
      end
   end

   spcr_front #(
      .FRAC_BITS(FRAC_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .busy    (busy),
      .req_data(req_data),
      .rs      (rs),
      .qstat   (qstat),
      .qpush   (qpush)
   );

   spcr_queue u_queue (
      .clock(clock),
      .reset(reset),
      .qpush(qpush),
      .pop  (pop),
      .head (head),
      .qstat(qstat)
   );

   spcr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .qstat      (qstat),
      .pop        (pop),
      .rs         (rs),
      .restitution(restitution_ff),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule
